[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/mlfq_pkg.sv]
// Types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] job_id;
    logic [7:0]  job_priority;
    logic [15:0] burst_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_job_id;
    logic [7:0]  out_priority;
    logic [15:0] out_burst;
    logic [15:0] out_remaining;
    logic [2:0]  out_level;
    logic [31:0] turnaround;
    logic [31:0] clock_now;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [31:0] arrival;
  } entry_t;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] y;
    logic        cout;
  } alu_rsp_t;

  localparam logic [1:0] ACT_CREATE      = 2'd0;
  localparam logic [1:0] ACT_RUN_ARRIVAL = 2'd1;
  localparam logic [1:0] ACT_RUN_ANY     = 2'd2;
  localparam logic [1:0] ACT_NONE        = 2'd3;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_REQUEUED  = 3'd1;
  localparam logic [2:0] ST_FINISHED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ARR_EMPTY = 3'd4;
  localparam logic [2:0] ST_ALL_EMPTY = 3'd5;

  localparam logic [15:0] QUANTUM_RESET = 16'd20;

endpackage

[design/mlfq_alu.sv]
// Shared 32-bit add/subtract unit of the scheduler.
module mlfq_alu (
  input  mlfq_pkg::alu_req_t req,
  output mlfq_pkg::alu_rsp_t rsp
);

  logic [32:0] sum;

  always_comb begin
    if (req.op == mlfq_pkg::ALU_SUB) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.y    = sum[31:0];
    rsp.cout = sum[32];
  end

endmodule

[design/mlfq_mem.sv]
// Job entry memory: one write port, one registered read port.
module mlfq_mem #(
  parameter int DEPTH  = 640,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  mlfq_pkg::entry_t    wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output mlfq_pkg::entry_t    rd_data
);

  mlfq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/multilevel_feedback_queue_scheduler.sv]
// Top level of the multilevel feedback queue scheduler.
//
//   channel | ports                      | payload
//   --------+----------------------------+---------------------------
//   in      | in_valid / in_ready        | in_data  (mlfq_pkg::in_t)
//   out     | out_valid / out_ready      | out_data (mlfq_pkg::out_t)
//   cfg     | cfg_valid / cfg_ready      | cfg_data (time quantum)
//
// A run item passes DECODE (entry read), CMP, CLK, TURN and FIN; a create or empty-queue item
// passes DECODE and FIN. The run steps follow from the one shared 32-bit adder: quantum compare,
// clock advance and turnaround each take a pass, after the registered entry memory read.
// in_ready is high only while idle; a finished result waits in the output register.
// Reset is synchronous: queues empty, clock zero, quantum 20; no memory clearing.
module multilevel_feedback_queue_scheduler #(
  parameter int QUEUE_DEPTH = 128,
  parameter int NUM_LEVELS  = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlfq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mlfq_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  localparam int NQ     = NUM_LEVELS + 1;
  localparam int NSLOTS = NQ * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(NSLOTS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int LVL_W  = $clog2(NQ);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_CLK    = 3'd3;
  localparam logic [2:0] S_TURN   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [LVL_W-1:0] q,
                                                input logic [PTR_W-1:0] p);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [2:0]          state_r, state_nxt;
  mlfq_pkg::in_t       item_r, item_nxt;
  logic [LVL_W-1:0]    src_r, src_nxt;
  logic [LVL_W-1:0]    dst_r, dst_nxt;
  logic [2:0]          st_r, st_nxt;
  logic [15:0]         rem_new_r, rem_new_nxt;
  logic [31:0]         clk_new_r, clk_new_nxt;
  logic [31:0]         ta_r, ta_nxt;
  logic [31:0]         sched_clock_r, sched_clock_nxt;
  logic [15:0]         quantum_r, quantum_nxt;
  logic [PTR_W-1:0]    head_r [NQ];
  logic [PTR_W-1:0]    head_nxt [NQ];
  logic [PTR_W-1:0]    tail_r [NQ];
  logic [PTR_W-1:0]    tail_nxt [NQ];
  logic                out_valid_r, out_valid_nxt;
  mlfq_pkg::out_t      out_data_r, out_data_nxt;

  logic [NQ-1:0]       empty_v;
  logic [NQ-1:0]       full_v;
  logic [LVL_W-1:0]    pick;
  logic [LVL_W-1:0]    rd_src;
  logic [LVL_W-1:0]    dst_calc;
  logic                demote;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  mlfq_pkg::entry_t    rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  mlfq_pkg::entry_t    wr_data;

  mlfq_pkg::alu_req_t  alu_req;
  mlfq_pkg::alu_rsp_t  alu_rsp;

  mlfq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  mlfq_mem #(
    .DEPTH  (NSLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      empty_v[i] = (head_r[i] == tail_r[i]);
      full_v[i]  = (wrap_ptr(tail_r[i]) == head_r[i]);
    end
  end

  // first nonempty queue, arrival queue first
  always_comb begin
    pick = '0;
    for (int i = NQ - 1; i >= 0; i--) begin
      if (!empty_v[i]) begin
        pick = LVL_W'(i);
      end
    end
  end

  assign rd_src   = (item_r.action == mlfq_pkg::ACT_RUN_ARRIVAL) ? '0 : pick;
  assign dst_calc = (src_r < LVL_W'(NUM_LEVELS)) ? src_r + 1'b1 : LVL_W'(NUM_LEVELS);
  assign demote   = !alu_rsp.cout && (alu_rsp.y != 32'd0);

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    src_nxt         = src_r;
    dst_nxt         = dst_r;
    st_nxt          = st_r;
    rem_new_nxt     = rem_new_r;
    clk_new_nxt     = clk_new_r;
    ta_nxt          = ta_r;
    sched_clock_nxt = sched_clock_r;
    quantum_nxt     = cfg_valid ? cfg_data : quantum_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    rd_en           = 1'b0;
    rd_addr         = slot_of(rd_src, head_r[rd_src]);
    wr_en           = 1'b0;
    wr_addr         = slot_of(dst_r, tail_r[dst_r]);
    wr_data         = rd_data;
    alu_req.op      = mlfq_pkg::ALU_SUB;
    alu_req.a       = {16'd0, rd_data.remaining};
    alu_req.b       = {16'd0, quantum_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (item_r.action)
          mlfq_pkg::ACT_CREATE: begin
            st_nxt    = full_v[0] ? mlfq_pkg::ST_FULL : mlfq_pkg::ST_CREATED;
            state_nxt = S_FIN;
          end
          mlfq_pkg::ACT_RUN_ARRIVAL: begin
            if (empty_v[0]) begin
              st_nxt    = mlfq_pkg::ST_ARR_EMPTY;
              state_nxt = S_FIN;
            end else begin
              src_nxt   = rd_src;
              rd_en     = 1'b1;
              state_nxt = S_CMP;
            end
          end
          mlfq_pkg::ACT_RUN_ANY: begin
            if (&empty_v) begin
              st_nxt    = mlfq_pkg::ST_ALL_EMPTY;
              state_nxt = S_FIN;
            end else begin
              src_nxt   = rd_src;
              rd_en     = 1'b1;
              state_nxt = S_CMP;
            end
          end
          mlfq_pkg::ACT_NONE: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CMP: begin
        // remaining - quantum; demote when strictly positive
        rem_new_nxt = alu_rsp.y[15:0];
        dst_nxt     = dst_calc;
        if (demote) begin
          st_nxt = (dst_calc != src_r && full_v[dst_calc]) ? mlfq_pkg::ST_FULL
                                                           : mlfq_pkg::ST_REQUEUED;
        end else begin
          st_nxt = mlfq_pkg::ST_FINISHED;
        end
        state_nxt = S_CLK;
      end
      S_CLK: begin
        alu_req.op  = mlfq_pkg::ALU_ADD;
        alu_req.a   = sched_clock_r;
        alu_req.b   = (st_r == mlfq_pkg::ST_REQUEUED) ? {16'd0, quantum_r}
                                                      : {16'd0, rd_data.remaining};
        clk_new_nxt = alu_rsp.y;
        state_nxt   = S_TURN;
      end
      S_TURN: begin
        alu_req.op = mlfq_pkg::ALU_SUB;
        alu_req.a  = clk_new_r;
        alu_req.b  = rd_data.arrival;
        ta_nxt     = alu_rsp.y;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
          out_data_nxt           = '0;
          out_data_nxt.status    = st_r;
          out_data_nxt.clock_now = sched_clock_r;
          case (st_r)
            mlfq_pkg::ST_CREATED: begin
              out_data_nxt.out_job_id    = item_r.job_id;
              out_data_nxt.out_priority  = item_r.job_priority;
              out_data_nxt.out_burst     = item_r.burst_length;
              out_data_nxt.out_remaining = item_r.burst_length;
              wr_en             = 1'b1;
              wr_addr           = slot_of('0, tail_r[0]);
              wr_data.id        = item_r.job_id;
              wr_data.prio      = item_r.job_priority;
              wr_data.burst     = item_r.burst_length;
              wr_data.remaining = item_r.burst_length;
              wr_data.arrival   = sched_clock_r;
              tail_nxt[0]       = wrap_ptr(tail_r[0]);
            end
            mlfq_pkg::ST_FULL: begin
              if (item_r.action == mlfq_pkg::ACT_CREATE) begin
                out_data_nxt.out_job_id    = item_r.job_id;
                out_data_nxt.out_priority  = item_r.job_priority;
                out_data_nxt.out_burst     = item_r.burst_length;
                out_data_nxt.out_remaining = item_r.burst_length;
              end else begin
                out_data_nxt.out_job_id    = rd_data.id;
                out_data_nxt.out_priority  = rd_data.prio;
                out_data_nxt.out_burst     = rd_data.burst;
                out_data_nxt.out_remaining = rd_data.remaining;
                out_data_nxt.out_level     = 3'(src_r);
              end
            end
            mlfq_pkg::ST_REQUEUED: begin
              out_data_nxt.out_job_id    = rd_data.id;
              out_data_nxt.out_priority  = rd_data.prio;
              out_data_nxt.out_burst     = rd_data.burst;
              out_data_nxt.out_remaining = rem_new_r;
              out_data_nxt.out_level     = 3'(dst_r);
              out_data_nxt.clock_now     = clk_new_r;
              wr_en             = 1'b1;
              wr_data.remaining = rem_new_r;
              head_nxt[src_r]   = wrap_ptr(head_r[src_r]);
              tail_nxt[dst_r]   = wrap_ptr(tail_r[dst_r]);
              sched_clock_nxt   = clk_new_r;
            end
            mlfq_pkg::ST_FINISHED: begin
              out_data_nxt.out_job_id   = rd_data.id;
              out_data_nxt.out_priority = rd_data.prio;
              out_data_nxt.out_burst    = rd_data.burst;
              out_data_nxt.out_level    = 3'(src_r);
              out_data_nxt.turnaround   = ta_r;
              out_data_nxt.clock_now    = clk_new_r;
              head_nxt[src_r]           = wrap_ptr(head_r[src_r]);
              sched_clock_nxt           = clk_new_r;
            end
            default: begin
              // empty queue: job fields stay zero
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sched_clock_r <= '0;
      quantum_r     <= mlfq_pkg::QUANTUM_RESET;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      sched_clock_r <= sched_clock_nxt;
      quantum_r     <= quantum_nxt;
      out_valid_r   <= out_valid_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    st_r       <= st_nxt;
    rem_new_r  <= rem_new_nxt;
    clk_new_r  <= clk_new_nxt;
    ta_r       <= ta_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[design/mlfq_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
`include "assert_macros.svh"

module mlfq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mlfq_pkg::out_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  `ASSERT_IMPL(a_ta_only_finish, clk, rst_n, out_valid && out_data.status != mlfq_pkg::ST_FINISHED, out_data.turnaround == 32'd0)

  `ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && (out_data.status == mlfq_pkg::ST_ARR_EMPTY || out_data.status == mlfq_pkg::ST_ALL_EMPTY), out_data.out_job_id == 16'd0 && out_data.out_remaining == 16'd0 && out_data.out_level == 3'd0)

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_checker (.*);
